// ===== rtl/core/mag_seq_pkg.sv =====
// ---------------------------------------------------------------------------
// mag_seq_pkg
// shared types, register map constants and the decode helper of the
// magnetometer poll sequencer
// ---------------------------------------------------------------------------
package mag_seq_pkg;

   localparam int unsigned ADDR_W       = 7;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned SAMPLE_BYTES = 6;
   localparam int unsigned SAMPLE_IDX_W = 3;
   localparam int unsigned CSR_INDEX_W  = 2;

   // sensor register map
   localparam logic [BYTE_W-1:0] REG_ID     = 8'h0F;
   localparam logic [BYTE_W-1:0] REG_CTRL1  = 8'h20;
   localparam logic [BYTE_W-1:0] REG_CTRL3  = 8'h22;
   localparam logic [BYTE_W-1:0] REG_CTRL4  = 8'h23;
   localparam logic [BYTE_W-1:0] REG_STATUS = 8'h27;
   localparam logic [BYTE_W-1:0] REG_OUT    = 8'h28;
   localparam int unsigned       STATUS_READY_BIT = 3;

   // csr reset values
   localparam logic [ADDR_W-1:0] DEV_ADDR_RST = 7'h1E;
   localparam logic [BYTE_W-1:0] XY_MODE_RST  = 8'h70;  // om1 | om0 | do2
   localparam logic [BYTE_W-1:0] Z_MODE_RST   = 8'h0C;  // oz1 | oz0
   localparam logic [BYTE_W-1:0] TRIG_RST     = 8'h01;  // md0

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEVICE_ADDRESS = 2'd0,
      CSR_XY_MODE        = 2'd1,
      CSR_Z_MODE         = 2'd2,
      CSR_TRIGGER        = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_STEP      = 2'd0,
      KIND_ADDR_DONE = 2'd1,
      KIND_TRIGGER   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CMD_NONE         = 2'd0,
      CMD_START_WRITE  = 2'd1,
      CMD_WRITE_DATA   = 2'd2,
      CMD_RESTART_READ = 2'd3
   } cmd_code_type;

   typedef enum logic [1:0] {
      CB_NONE  = 2'd0,
      CB_WRITE = 2'd1,
      CB_READ  = 2'd2
   } callback_type;

   typedef enum logic [4:0] {
      ST_INIT_XY    = 5'd0,
      ST_INIT_Z     = 5'd1,
      ST_ID_REQ     = 5'd2,
      ST_ID_WAIT    = 5'd3,
      ST_ID_RESP    = 5'd4,
      ST_TRIG_WAIT  = 5'd5,
      ST_TRIG_REQ   = 5'd6,
      ST_POLL_REQ   = 5'd7,
      ST_POLL_WAIT  = 5'd8,
      ST_POLL_RESP  = 5'd9,
      ST_X_LO_REQ   = 5'd10,
      ST_X_LO_WAIT  = 5'd11,
      ST_X_LO_RESP  = 5'd12,
      ST_X_HI_REQ   = 5'd13,
      ST_X_HI_WAIT  = 5'd14,
      ST_X_HI_RESP  = 5'd15,
      ST_Y_LO_REQ   = 5'd16,
      ST_Y_LO_WAIT  = 5'd17,
      ST_Y_LO_RESP  = 5'd18,
      ST_Y_HI_REQ   = 5'd19,
      ST_Y_HI_WAIT  = 5'd20,
      ST_Y_HI_RESP  = 5'd21,
      ST_Z_LO_REQ   = 5'd22,
      ST_Z_LO_WAIT  = 5'd23,
      ST_Z_LO_RESP  = 5'd24,
      ST_Z_HI_REQ   = 5'd25,
      ST_Z_HI_WAIT  = 5'd26,
      ST_Z_HI_RESP  = 5'd27
   } seq_state_type;

   typedef enum logic [1:0] {
      PH_REQ  = 2'd0,
      PH_WAIT = 2'd1,
      PH_RESP = 2'd2
   } data_phase_type;

   typedef struct packed {
      logic [ADDR_W-1:0] device_address;
      logic [BYTE_W-1:0] xy_mode_value;
      logic [BYTE_W-1:0] z_mode_value;
      logic [BYTE_W-1:0] trigger_value;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic              bus_busy;
      logic [BYTE_W-1:0] read_byte;
   } req_word_type;

   // control context carried from one word to the next
   typedef struct packed {
      seq_state_type     state;
      callback_type      callback;
      logic [BYTE_W-1:0] write_byte;
   } ctx_type;

   // storage updates requested by the sequencer for one word
   typedef struct packed {
      ctx_type                 ctx;
      logic                    sample_we;
      logic [SAMPLE_IDX_W-1:0] sample_idx;
      logic                    id_we;
      logic                    flag_set;
   } upd_type;

   typedef struct packed {
      cmd_code_type      code;
      logic [ADDR_W-1:0] device;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic                    hit;
      logic [SAMPLE_IDX_W-1:0] idx;
      data_phase_type          phase;
   } data_slot_type;

   // split a data-read state into byte index and phase (offset / 3 by reciprocal)
   function automatic data_slot_type data_slot(input seq_state_type state);
      logic [4:0]    off;
      logic [8:0]    prod;
      data_slot_type slot;
      off        = 5'(state) - 5'(ST_X_LO_REQ);
      prod       = 9'(off) * 9'd11;
      slot.hit   = (5'(state) >= 5'(ST_X_LO_REQ)) && (5'(state) <= 5'(ST_Z_HI_RESP));
      slot.idx   = prod[7:5];
      slot.phase = data_phase_type'(2'(off - 5'(prod[7:5]) * 5'd3));
      return slot;
   endfunction

endpackage

// ===== rtl/core/mag_seq_if.sv =====
// ---------------------------------------------------------------------------
// mag_seq_req_if / mag_seq_rsp_if
// valid/ready channels of the magnetometer poll sequencer
// ---------------------------------------------------------------------------
interface mag_seq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic       bus_busy;
   logic [7:0] read_byte;

   modport source (output valid, kind, bus_busy, read_byte, input ready);
   modport sink   (input valid, kind, bus_busy, read_byte, output ready);
endinterface

interface mag_seq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [6:0]         command_device;
   logic [7:0]         command_byte;
   logic [7:0]         chip_id;
   logic signed [15:0] field_x;
   logic signed [15:0] field_y;
   logic signed [15:0] field_z;
   logic               new_sample;

   modport source (output valid, command, command_device, command_byte, chip_id,
                   field_x, field_y, field_z, new_sample, input ready);
   modport sink   (input valid, command, command_device, command_byte, chip_id,
                   field_x, field_y, field_z, new_sample, output ready);
endinterface

// ===== rtl/core/mag_seq_csr.sv =====
// ---------------------------------------------------------------------------
// mag_seq_csr
// configuration registers: device address and the three control bytes
// ---------------------------------------------------------------------------
module mag_seq_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [mag_seq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mag_seq_pkg::BYTE_W-1:0]        csr_wdata,
   output mag_seq_pkg::cfg_type                  cfg
);
   import mag_seq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_wdata[ADDR_W-1:0];
            CSR_XY_MODE:        cfg_in.xy_mode_value  = csr_wdata;
            CSR_Z_MODE:         cfg_in.z_mode_value   = csr_wdata;
            CSR_TRIGGER:        cfg_in.trigger_value  = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= DEV_ADDR_RST;
         cfg_ff.xy_mode_value  <= XY_MODE_RST;
         cfg_ff.z_mode_value   <= Z_MODE_RST;
         cfg_ff.trigger_value  <= TRIG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/mag_seq_fsm.sv =====
// ---------------------------------------------------------------------------
// mag_seq_fsm
// sequencer decode: next context, storage updates and bus command per word
// ---------------------------------------------------------------------------
module mag_seq_fsm (
   input  mag_seq_pkg::req_word_type word,
   input  mag_seq_pkg::ctx_type      ctx,
   input  mag_seq_pkg::cfg_type      cfg,
   output mag_seq_pkg::upd_type      upd,
   output mag_seq_pkg::cmd_type      cmd
);
   import mag_seq_pkg::*;

   data_slot_type slot;
   logic          read_advances;

   assign slot = data_slot(ctx.state);

   // a read callback moves on only from a wait state
   assign read_advances = (ctx.state == ST_ID_WAIT) || (ctx.state == ST_POLL_WAIT) ||
                          (slot.hit && (slot.phase == PH_WAIT));

   // next state and storage updates
   always_comb begin
      upd            = '0;
      upd.ctx        = ctx;
      upd.sample_idx = slot.idx;
      unique case (word.kind)
         KIND_STEP: begin
            if (!word.bus_busy) begin
               unique case (ctx.state)
                  ST_INIT_XY: begin
                     upd.ctx.state      = ST_INIT_Z;
                     upd.ctx.callback   = CB_WRITE;
                     upd.ctx.write_byte = cfg.xy_mode_value;
                  end
                  ST_INIT_Z: begin
                     upd.ctx.state      = ST_ID_REQ;
                     upd.ctx.callback   = CB_WRITE;
                     upd.ctx.write_byte = cfg.z_mode_value;
                  end
                  ST_ID_REQ: begin
                     upd.ctx.state    = ST_ID_WAIT;
                     upd.ctx.callback = CB_READ;
                  end
                  ST_ID_RESP: begin
                     upd.id_we     = 1'b1;
                     upd.ctx.state = ST_TRIG_WAIT;
                  end
                  ST_TRIG_REQ: begin
                     upd.ctx.state      = ST_POLL_REQ;
                     upd.ctx.callback   = CB_WRITE;
                     upd.ctx.write_byte = cfg.trigger_value;
                  end
                  ST_POLL_REQ: begin
                     upd.ctx.state    = ST_POLL_WAIT;
                     upd.ctx.callback = CB_READ;
                  end
                  ST_POLL_RESP: begin
                     upd.ctx.state = word.read_byte[STATUS_READY_BIT] ? ST_X_LO_REQ
                                                                      : ST_POLL_REQ;
                  end
                  default: begin
                     if (slot.hit && (slot.phase == PH_REQ)) begin
                        upd.ctx.state    = seq_state_type'(5'(ctx.state) + 5'd1);
                        upd.ctx.callback = CB_READ;
                     end else if (slot.hit && (slot.phase == PH_RESP)) begin
                        upd.sample_we = 1'b1;
                        if (ctx.state == ST_Z_HI_RESP) begin
                           upd.ctx.state = ST_TRIG_WAIT;
                           upd.flag_set  = 1'b1;
                        end else begin
                           upd.ctx.state = seq_state_type'(5'(ctx.state) + 5'd1);
                        end
                     end
                  end
               endcase
            end
         end
         KIND_ADDR_DONE: begin
            if ((ctx.callback == CB_READ) && read_advances) begin
               upd.ctx.state = seq_state_type'(5'(ctx.state) + 5'd1);
            end
         end
         KIND_TRIGGER: upd.ctx.state = ST_TRIG_REQ;
         default: ;
      endcase
   end

   // bus command
   always_comb begin
      cmd = '0;
      unique case (word.kind)
         KIND_STEP: begin
            if (!word.bus_busy) begin
               unique case (ctx.state)
                  ST_INIT_XY: begin
                     cmd.code = CMD_START_WRITE;
                     cmd.data = REG_CTRL1;
                  end
                  ST_INIT_Z: begin
                     cmd.code = CMD_START_WRITE;
                     cmd.data = REG_CTRL4;
                  end
                  ST_ID_REQ: begin
                     cmd.code = CMD_START_WRITE;
                     cmd.data = REG_ID;
                  end
                  ST_TRIG_REQ: begin
                     cmd.code = CMD_START_WRITE;
                     cmd.data = REG_CTRL3;
                  end
                  ST_POLL_REQ: begin
                     cmd.code = CMD_START_WRITE;
                     cmd.data = REG_STATUS;
                  end
                  default: begin
                     if (slot.hit && (slot.phase == PH_REQ)) begin
                        cmd.code = CMD_START_WRITE;
                        cmd.data = REG_OUT + BYTE_W'(slot.idx);
                     end
                  end
               endcase
               if (cmd.code == CMD_START_WRITE) begin
                  cmd.device = cfg.device_address;
               end
            end
         end
         KIND_ADDR_DONE: begin
            unique case (ctx.callback)
               CB_WRITE: begin
                  cmd.code = CMD_WRITE_DATA;
                  cmd.data = ctx.write_byte;
               end
               CB_READ: begin
                  cmd.code   = CMD_RESTART_READ;
                  cmd.device = cfg.device_address;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/core/magnetometer_i2c_poll_sequencer_unit.sv =====
// ---------------------------------------------------------------------------
// magnetometer_i2c_poll_sequencer_unit
// bus command sequencer for a three-axis magnetometer on a byte-level i2c master
// ---------------------------------------------------------------------------
// each request word is one event (step, address phase done, trigger) and gives
// exactly one response word: the bus command to issue (none, start write with a
// register byte, write data byte, repeated start read) together with the stored
// chip id, the three joined samples and the sticky new-sample flag as they
// stand after the event. after reset the unit writes the xy and z mode bytes,
// reads the id register, then waits for a trigger; a trigger writes the
// single-shot byte, polls status bit 3 and reads the six output bytes. a step
// with bus_busy set does nothing, a trigger abandons any sequence in progress.
// throughput is one word per clock while each response is taken when offered;
// a word passes through the input register, then the result register, whose
// output is the response. the rate is set by the loop through the sequence
// state register. the request side keeps accepting while a finished response
// waits to be taken, and stalls only when both the input and result registers
// hold words.
// configuration registers must only be written while no word is in flight.
// ---------------------------------------------------------------------------
module magnetometer_i2c_poll_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,
   mag_seq_req_if.sink                         req_if,
   mag_seq_rsp_if.source                       rsp_if,
   input  logic                                csr_we,
   input  logic [mag_seq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mag_seq_pkg::BYTE_W-1:0]      csr_wdata
);
   import mag_seq_pkg::*;

   typedef struct packed {
      cmd_type                  cmd;
      logic [BYTE_W-1:0]        chip_id;
      logic [2*BYTE_W-1:0]      field_x;
      logic [2*BYTE_W-1:0]      field_y;
      logic [2*BYTE_W-1:0]      field_z;
      logic                     new_sample;
   } rsp_word_type;

   cfg_type            cfg;

   // input register
   logic               req_valid_ff;
   req_word_type       req_word_ff;
   logic               advance;

   // sequencer state and sample storage
   ctx_type            ctx_ff;
   logic [BYTE_W-1:0]  sample_ff [SAMPLE_BYTES];
   logic [BYTE_W-1:0]  sample_in [SAMPLE_BYTES];
   logic [BYTE_W-1:0]  id_ff;
   logic [BYTE_W-1:0]  id_in;
   logic               flag_ff;
   logic               flag_in;

   // result register
   logic               rsp_valid_ff;
   rsp_word_type       rsp_ff;
   rsp_word_type       rsp_in;

   upd_type            upd;
   cmd_type            cmd;

   mag_seq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mag_seq_fsm u_fsm (
      .word (req_word_ff),
      .ctx  (ctx_ff),
      .cfg  (cfg),
      .upd  (upd),
      .cmd  (cmd)
   );

   // the held word is processed when the result register is free or draining
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         req_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         req_word_ff.kind      <= req_if.kind;
         req_word_ff.bus_busy  <= req_if.bus_busy;
         req_word_ff.read_byte <= req_if.read_byte;
      end
   end

   // stored values after this word, reported with it
   always_comb begin
      for (int i = 0; i < SAMPLE_BYTES; i++) begin
         sample_in[i] = sample_ff[i];
      end
      if (upd.sample_we) begin
         sample_in[upd.sample_idx] = req_word_ff.read_byte;
      end
      id_in   = upd.id_we ? req_word_ff.read_byte : id_ff;
      flag_in = flag_ff | upd.flag_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.state      <= ST_INIT_XY;
         ctx_ff.callback   <= CB_NONE;
         ctx_ff.write_byte <= '0;
         for (int i = 0; i < SAMPLE_BYTES; i++) begin
            sample_ff[i] <= '0;
         end
         id_ff   <= '0;
         flag_ff <= 1'b0;
      end else if (advance) begin
         ctx_ff <= upd.ctx;
         for (int i = 0; i < SAMPLE_BYTES; i++) begin
            sample_ff[i] <= sample_in[i];
         end
         id_ff   <= id_in;
         flag_ff <= flag_in;
      end
   end

   always_comb begin
      rsp_in.cmd        = cmd;
      rsp_in.chip_id    = id_in;
      rsp_in.field_x    = {sample_in[1], sample_in[0]};
      rsp_in.field_y    = {sample_in[3], sample_in[2]};
      rsp_in.field_z    = {sample_in[5], sample_in[4]};
      rsp_in.new_sample = flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.command        = rsp_ff.cmd.code;
   assign rsp_if.command_device = rsp_ff.cmd.device;
   assign rsp_if.command_byte   = rsp_ff.cmd.data;
   assign rsp_if.chip_id        = rsp_ff.chip_id;
   assign rsp_if.field_x        = signed'(rsp_ff.field_x);
   assign rsp_if.field_y        = signed'(rsp_ff.field_y);
   assign rsp_if.field_z        = signed'(rsp_ff.field_z);
   assign rsp_if.new_sample     = rsp_ff.new_sample;

endmodule
